// ===== hdl/bpid_pkg.sv =====
`timescale 1ns / 1ps

package bpid_pkg;

	localparam int FRAC_BITS_DEF = 8;
	localparam int CFG_W         = 31;
	localparam int CFG_IDX_W     = 3;
	localparam int INT_W         = 32;
	localparam int OP_A_W        = 17;
	localparam int OP_B_W        = 32;
	localparam int PROD_W        = OP_A_W + OP_B_W;

	// integration step 0.01 s in Q0.16
	localparam logic signed [OP_B_W-1:0] DT_Q016 = 32'sd655;

	localparam logic [30:0] INT_LIMIT_RST = 31'h7fff_ffff;
	localparam logic [14:0] MAX_SPEED_RST = 15'h7fff;
	localparam logic [14:0] FALL_THR_RST  = 15'h7fff;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_SPEED_SP,
		REG_ANGLE_OFS,
		REG_INT_LIMIT,
		REG_MAX_SPEED,
		REG_FALL_THR
	} cfg_reg_t;

	typedef struct packed {
		logic signed [15:0] pitch_angle;
		logic signed [15:0] pitch_rate;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] motor_drive;
		logic               balanced;
	} out_word_t;

	typedef enum logic [1:0] {
		MS_ERR_DT,
		MS_P_ERR,
		MS_I_INT,
		MS_D_RATE
	} mul_sel_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LOAD_SP,
		ACC_ADD,
		ACC_ADD_I,
		ACC_SUB
	} acc_op_t;

	typedef enum logic [2:0] {
		ST_FETCH,
		ST_INC,
		ST_INT,
		ST_P,
		ST_I,
		ST_D,
		ST_OUT
	} step_t;

	typedef struct packed {
		logic     wait_in;
		logic     wait_out;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     int_upd;
		logic     out_wr;
		step_t    next;
	} ctrl_t;

	// microprogram: one control word per step
	function automatic ctrl_t ucode(input step_t s);
		ctrl_t c;
		c = '{wait_in: 1'b0, wait_out: 1'b0, mul_sel: MS_ERR_DT, acc_op: ACC_HOLD,
			int_upd: 1'b0, out_wr: 1'b0, next: ST_FETCH};
		unique case (s)
			ST_FETCH: begin
				c.wait_in = 1'b1;
				c.next    = ST_INC;
			end
			ST_INC: begin
				c.mul_sel = MS_ERR_DT;
				c.next    = ST_INT;
			end
			ST_INT: begin
				c.int_upd = 1'b1;
				c.acc_op  = ACC_LOAD_SP;
				c.mul_sel = MS_P_ERR;
				c.next    = ST_P;
			end
			ST_P: begin
				c.acc_op  = ACC_ADD;
				c.mul_sel = MS_I_INT;
				c.next    = ST_I;
			end
			ST_I: begin
				c.acc_op  = ACC_ADD_I;
				c.mul_sel = MS_D_RATE;
				c.next    = ST_D;
			end
			ST_D: begin
				c.acc_op = ACC_SUB;
				c.next   = ST_OUT;
			end
			ST_OUT: begin
				c.wait_out = 1'b1;
				c.out_wr   = 1'b1;
				c.next     = ST_FETCH;
			end
			default: begin
				c.next = ST_FETCH;
			end
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/balance_pid_controller.sv =====
`timescale 1ns / 1ps

// the accepted word passes the inc, int, p, i and d steps and is written to the output
// register in the out step once the output is free; the 7-step microprogram runs
// every product through one shared 17x32 multiplier, and takes a new word only at fetch
// the next input word is taken while a finished result still waits at the output
// reset: gains, setpoint and offset to zero, limits and threshold to full scale,
// integral to zero, sequencer at the fetch step, no result pending
module balance_pid_controller #(
	parameter int FRAC_BITS = bpid_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bpid_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bpid_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  bpid_pkg::in_word_t             in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output bpid_pkg::out_word_t            out_data
);
	import bpid_pkg::*;

	localparam int ACC_W = FRAC_BITS + 36;

	logic signed [15:0] gain_p_q, gain_i_q, gain_d_q, speed_sp_q, angle_ofs_q;
	logic [30:0]        int_limit_q;
	logic [14:0]        max_speed_q, fall_thr_q;

	step_t step_q;
	ctrl_t cw;

	logic signed [16:0]        err_q;
	logic signed [15:0]        rate_q;
	logic                      balanced_q;
	logic signed [INT_W-1:0]   integ_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      out_valid_q;
	out_word_t                 out_data_q;

	logic                      accept;
	logic                      hold;
	logic signed [OP_A_W-1:0]  mul_a;
	logic signed [OP_B_W-1:0]  mul_b;
	logic signed [16:0]        angle_ext;
	logic [16:0]               angle_mag;
	logic signed [32:0]        int_sum;
	logic signed [32:0]        int_lim;
	logic signed [INT_W-1:0]   integ_next;
	logic signed [ACC_W-1:0]   acc_next;
	logic signed [ACC_W-1:0]   acc_shr;
	logic signed [ACC_W-1:0]   drive_lim;
	logic signed [15:0]        drive;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			speed_sp_q  <= '0;
			angle_ofs_q <= '0;
			int_limit_q <= INT_LIMIT_RST;
			max_speed_q <= MAX_SPEED_RST;
			fall_thr_q  <= FALL_THR_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GAIN_P:    gain_p_q    <= cfg_data[15:0];
				REG_GAIN_I:    gain_i_q    <= cfg_data[15:0];
				REG_GAIN_D:    gain_d_q    <= cfg_data[15:0];
				REG_SPEED_SP:  speed_sp_q  <= cfg_data[15:0];
				REG_ANGLE_OFS: angle_ofs_q <= cfg_data[15:0];
				REG_INT_LIMIT: int_limit_q <= cfg_data[30:0];
				REG_MAX_SPEED: max_speed_q <= cfg_data[14:0];
				REG_FALL_THR:  fall_thr_q  <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// sequencer
	assign cw       = ucode(step_q);
	assign in_ready = cw.wait_in;
	assign accept   = in_valid && in_ready;
	assign hold     = (cw.wait_in && !in_valid) || (cw.wait_out && out_valid_q && !out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_FETCH;
		end else if (!hold) begin
			step_q <= cw.next;
		end
	end

	// input capture
	assign angle_ext = 17'(in_data.pitch_angle);
	assign angle_mag = angle_ext[16] ? 17'(-angle_ext) : angle_ext;

	always_ff @(posedge clk) begin
		if (accept) begin
			err_q      <= angle_ext - 17'(angle_ofs_q);
			rate_q     <= in_data.pitch_rate;
			balanced_q <= angle_mag < {2'b00, fall_thr_q};
		end
	end

	// shared multiplier
	always_comb begin
		mul_a = OP_A_W'(err_q);
		mul_b = DT_Q016;
		case (cw.mul_sel)
			MS_ERR_DT: begin
				mul_a = OP_A_W'(err_q);
				mul_b = DT_Q016;
			end
			MS_P_ERR: begin
				mul_a = OP_A_W'(gain_p_q);
				mul_b = OP_B_W'(err_q);
			end
			MS_I_INT: begin
				mul_a = OP_A_W'(gain_i_q);
				mul_b = integ_q;
			end
			MS_D_RATE: begin
				mul_a = OP_A_W'(gain_d_q);
				mul_b = OP_B_W'(rate_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	// integral with symmetric clamp
	assign int_sum = 33'(integ_q) + 33'(prod_q >>> FRAC_BITS);
	assign int_lim = $signed({2'b00, int_limit_q});

	always_comb begin
		if (int_sum > int_lim) begin
			integ_next = INT_W'(int_lim);
		end else if (int_sum < -int_lim) begin
			integ_next = INT_W'(-int_lim);
		end else begin
			integ_next = int_sum[INT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (cw.int_upd) begin
			integ_q <= integ_next;
		end
	end

	// drive accumulator, terms carry FRAC_BITS fraction bits
	always_comb begin
		acc_next = acc_q;
		case (cw.acc_op)
			ACC_HOLD:    acc_next = acc_q;
			ACC_LOAD_SP: acc_next = ACC_W'(speed_sp_q) <<< FRAC_BITS;
			ACC_ADD:     acc_next = acc_q + ACC_W'(prod_q);
			ACC_ADD_I:   acc_next = acc_q + ACC_W'(prod_q >>> (16 - FRAC_BITS));
			ACC_SUB:     acc_next = acc_q - ACC_W'(prod_q);
			default:     acc_next = acc_q;
		endcase
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_next;
	end

	// final scale and saturation
	assign acc_shr   = acc_q >>> FRAC_BITS;
	assign drive_lim = ACC_W'($signed({1'b0, max_speed_q}));

	always_comb begin
		if (acc_shr > drive_lim) begin
			drive = 16'(drive_lim);
		end else if (acc_shr < -drive_lim) begin
			drive = 16'(-drive_lim);
		end else begin
			drive = acc_shr[15:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cw.out_wr && !hold) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.out_wr && !hold) begin
			out_data_q.motor_drive <= drive;
			out_data_q.balanced    <= balanced_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== hdl/bpid_checker.sv =====
`timescale 1ns / 1ps

module bpid_props (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_we,
	input logic [bpid_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [bpid_pkg::CFG_W-1:0]     cfg_data,
	input logic                           in_valid,
	input logic                           in_ready,
	input bpid_pkg::in_word_t             in_data,
	input logic                           out_valid,
	input logic                           out_ready,
	input bpid_pkg::out_word_t            out_data
);
	import bpid_pkg::*;

	// a stalled result word stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result word changed while stalled");

	// one word in flight: no new word right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a word is in flight");

	// a fresh result follows an accepted input word
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 7))
		else $error("result without matching input word");

	// configuration writes land between words, or continue a run of writes that began there
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> in_ready || $past(cfg_we))
		else $error("configuration written during a computation");

endmodule

bind balance_pid_controller bpid_props u_bpid_props (.*);

// ===== bench/bpid_checker.sv =====
`timescale 1ns / 1ps

module bpid_checker #(
	parameter int FRAC_BITS = bpid_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bpid_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bpid_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  bpid_pkg::in_word_t             in_data,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  bpid_pkg::out_word_t            out_data,
	output int                             pending,
	output int                             errors
);

	import bpid_pkg::*;

	typedef struct {
		in_word_t  sample;
		out_word_t drive;
	} drive_exp_t;

	// local copy of the tuning registers and the integrator
	logic signed [15:0] kp, ki, kd, speed_sp, angle_ofs;
	logic [30:0]        int_lim;
	logic [14:0]        max_spd, fall_thr;
	logic signed [31:0] err_integ;

	drive_exp_t drive_q[$];

	function automatic longint clamp_sym(longint x, longint lim);
		if (x > lim)
			return lim;
		if (x < -lim)
			return -lim;
		return x;
	endfunction

	// advances the integrator and forms the saturated drive for one sample
	function automatic out_word_t pid_drive(in_word_t w);
		longint    angle, rate, err, integ, sum, drv, mag;
		out_word_t o;
		angle = w.pitch_angle;
		rate  = w.pitch_rate;
		err   = angle - longint'(angle_ofs);
		integ = clamp_sym(longint'(err_integ) + ((err * longint'(DT_Q016)) >>> FRAC_BITS),
			longint'(int_lim));
		err_integ = integ[31:0];
		sum = longint'(kp) * err
			+ ((longint'(ki) * integ) >>> (16 - FRAC_BITS))
			- longint'(kd) * rate
			+ (longint'(speed_sp) <<< FRAC_BITS);
		drv = clamp_sym(sum >>> FRAC_BITS, longint'(max_spd));
		// most negative angle keeps its full magnitude
		mag = (angle < 0) ? -angle : angle;
		o.motor_drive = drv[15:0];
		o.balanced    = (mag < longint'(fall_thr));
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		drive_exp_t want;
		if (!arst_n) begin
			kp        = '0;
			ki        = '0;
			kd        = '0;
			speed_sp  = '0;
			angle_ofs = '0;
			int_lim   = INT_LIMIT_RST;
			max_spd   = MAX_SPEED_RST;
			fall_thr  = FALL_THR_RST;
			err_integ = '0;
			drive_q.delete();
			pending <= 0;
			errors  = 0;
		end else begin
			// result side first so a word taken this edge is never matched to itself
			if (out_valid && out_ready) begin
				if (drive_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected result: drive %0d balanced %0b",
							out_data.motor_drive, out_data.balanced);
					errors++;
				end else begin
					want = drive_q.pop_front();
					if (out_data.motor_drive !== want.drive.motor_drive ||
							out_data.balanced !== want.drive.balanced) begin
						if (errors < 10)
							$display("mismatch angle %0d rate %0d: expected %0d/%0b got %0d/%0b",
								want.sample.pitch_angle, want.sample.pitch_rate,
								want.drive.motor_drive, want.drive.balanced,
								out_data.motor_drive, out_data.balanced);
						errors++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_GAIN_P:    kp        = cfg_data[15:0];
					REG_GAIN_I:    ki        = cfg_data[15:0];
					REG_GAIN_D:    kd        = cfg_data[15:0];
					REG_SPEED_SP:  speed_sp  = cfg_data[15:0];
					REG_ANGLE_OFS: angle_ofs = cfg_data[15:0];
					REG_INT_LIMIT: int_lim   = cfg_data[30:0];
					REG_MAX_SPEED: max_spd   = cfg_data[14:0];
					REG_FALL_THR:  fall_thr  = cfg_data[14:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				want.sample = in_data;
				want.drive  = pid_drive(in_data);
				drive_q.push_back(want);
			end
			pending <= drive_q.size();
		end
	end

endmodule

// ===== bench/balance_pid_controller_tb.sv =====
`timescale 1ns / 1ps

module balance_pid_controller_tb;

	import bpid_pkg::*;

	localparam int FRAC        = FRAC_BITS_DEF;
	localparam int STALL_LIMIT = 5000;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 100;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_word_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_word_t            out_data;

	int pending;
	int errors;
	int idle_cycles = 0;
	int stall_left  = 0;
	bit in_burst    = 1'b0;
	bit out_burst   = 1'b0;

	logic signed [15:0] cur_ofs = '0;

	balance_pid_controller #(
		.FRAC_BITS(FRAC)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	bpid_checker #(
		.FRAC_BITS(FRAC)
	) u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.pending   (pending),
		.errors    (errors)
	);

	always #10 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int idle_len(bit burst);
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready  <= 1'b1;
			stall_left <= idle_len(out_burst);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_word(in_word_t w);
		int gap;
		gap = idle_len(in_burst);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send(logic signed [15:0] angle, logic signed [15:0] rate);
		send_word('{pitch_angle: angle, pitch_rate: rate});
	endtask

	// block is idle once every result is back: one result per word
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v;
		@(posedge clk);
	endtask

	// unused upper bits of the data word carry noise
	task automatic set_config(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
			logic [15:0] sp, logic [15:0] ofs, logic [30:0] lim,
			logic [14:0] ms, logic [14:0] thr);
		write_reg(REG_GAIN_P,    {15'($urandom), kp});
		write_reg(REG_GAIN_I,    {15'($urandom), ki});
		write_reg(REG_GAIN_D,    {15'($urandom), kd});
		write_reg(REG_SPEED_SP,  {15'($urandom), sp});
		write_reg(REG_ANGLE_OFS, {15'($urandom), ofs});
		write_reg(REG_INT_LIMIT, lim);
		write_reg(REG_MAX_SPEED, {16'($urandom), ms});
		write_reg(REG_FALL_THR,  {16'($urandom), thr});
		cfg_we  <= 1'b0;
		cur_ofs = ofs;
	endtask

	function automatic logic [15:0] rand_gain();
		if ($urandom_range(0, 3) == 0)
			return 16'($urandom);
		return 16'(int'($urandom_range(0, 2047)) - 1024);
	endfunction

	function automatic logic [30:0] rand_limit();
		case ($urandom_range(0, 3))
			0: return 31'($urandom_range(0, 50));
			1: return 31'($urandom_range(0, 65535));
			2: return 31'($urandom_range(0, 1 << 24));
			default: return 31'($urandom);
		endcase
	endfunction

	task automatic random_tuning();
		logic [14:0] ms;
		ms = ($urandom_range(0, 9) == 0) ? 15'd0 : 15'($urandom);
		set_config(rand_gain(), rand_gain(), rand_gain(),
			16'(int'($urandom_range(0, 4095)) - 2048),
			16'(int'($urandom_range(0, 4000)) - 2000),
			rand_limit(), ms, 15'($urandom));
	endtask

	// full-range noise or a word near the balance point
	task automatic random_word();
		in_word_t w;
		w = in_word_t'($urandom);
		if ($urandom_range(0, 9) >= 6) begin
			w.pitch_angle = 16'(int'(cur_ofs) + int'($urandom_range(0, 511)) - 256);
			w.pitch_rate  = 16'(int'($urandom_range(0, 4095)) - 2048);
		end
		send_word(w);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset tuning: zero drive, only the balance flag moves
		send(16'sd0, 16'sd0);
		send(16'sd32767, 16'sd0);
		send(16'sd32766, 16'sd0);
		send(-16'sd32768, 16'sd0);
		send(-16'sd32767, -16'sd32768);
		drain();

		set_config(16'd256, 16'd1024, 16'd256, 16'd100, -16'sd50,
			31'h7fff_ffff, 15'h7fff, 15'd1000);
		send(16'sd0, 16'sd0);
		send(16'sd999, 16'sd0);
		send(16'sd1000, 16'sd0);
		send(-16'sd1000, 16'sd32767);
		send(-16'sd999, -16'sd32768);
		send(16'sd32767, 16'sd32767);
		send(-16'sd32768, -16'sd32768);
		drain();

		// most negative gains and setpoint, most positive offset, zero integral limit, zero max speed, zero threshold
		set_config(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff,
			31'd0, 15'd0, 15'd0);
		send(-16'sd32768, 16'sd32767);
		send(16'sd32767, -16'sd32768);
		send(16'sd0, 16'sd0);
		drain();

		set_config(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000,
			31'h7fff_ffff, 15'h7fff, 15'h7fff);
		send(16'sd32767, -16'sd32768);
		send(-16'sd32768, 16'sd32767);
		send(16'sd123, -16'sd456);
		send(16'sd0, 16'sd1);
		drain();

		// small limit so the integral clamps on both sides
		set_config(16'd0, 16'h7fff, 16'd0, 16'd0, 16'd0,
			31'd1000, 15'h7fff, 15'h7fff);
		send(16'sd32767, 16'sd0);
		send(16'sd32767, 16'sd0);
		send(-16'sd32768, 16'sd0);
		send(-16'sd32768, 16'sd0);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			random_tuning();
			in_burst  = ($urandom_range(0, 3) == 0);
			out_burst = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_WORDS; n++)
				random_word();
			drain();
		end

		in_burst  = 1'b0;
		out_burst = 1'b0;
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
